// ===== design/per_stream_sequence_reorderer_macros.svh =====
// Assertion macros shared by the reorderer RTL.
// Used by psr_queue and psr_back; expect clk and rst_n in scope.
`ifndef PER_STREAM_SEQUENCE_REORDERER_MACROS_SVH
`define PER_STREAM_SEQUENCE_REORDERER_MACROS_SVH
`ifndef SYNTHESIS
`define PSR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("psr check failed");
`define PSR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("psr check failed");
`else
`define PSR_ASSERT_NOW(label, ante, cons)
`define PSR_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== design/psr_pkg.sv =====
// Package for the per-stream sequence reorderer: sizes, codes, command
// and stream state types. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package psr_pkg;

    localparam int STREAMS_PER_CLASS = 64;
    localparam int WINDOW            = 16;

    localparam int STREAM_W   = 6;
    localparam int SEQ_W      = 32;
    localparam int HANDLE_W   = 16;
    localparam int IDX_W      = $clog2(STREAMS_PER_CLASS);
    localparam int NSTREAMS   = 2 * STREAMS_PER_CLASS;
    localparam int SID_W      = $clog2(NSTREAMS);
    localparam int SLOT_W     = $clog2(WINDOW);
    localparam int CNT_W      = SLOT_W;
    localparam int HADDR_W    = SID_W + SLOT_W;
    localparam int HMEM_DEPTH = NSTREAMS * WINDOW;
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = $clog2(QDEPTH);

    typedef enum logic [1:0] {
        ST_RELEASED = 2'd0,
        ST_HELD     = 2'd1,
        ST_REJECTED = 2'd2,
        ST_CLEARED  = 2'd3
    } status_t;

    typedef enum logic {
        ACT_SUBMIT = 1'b0,
        ACT_CLEAR  = 1'b1
    } action_t;

    typedef struct packed {
        status_t               status;
        logic                  cls;
        logic [STREAM_W-1:0]   stream;
        logic [SEQ_W-1:0]      seq;
        logic [HANDLE_W-1:0]   handle;
        logic [CNT_W-1:0]      drain;
    } cmd_t;

    typedef struct packed {
        logic [SEQ_W-1:0]  expected;
        logic [WINDOW-1:0] held;
    } sstate_t;

    function automatic logic [SID_W-1:0] stream_id(input logic cls,
                                                   input logic [STREAM_W-1:0] strm);
        return {cls, strm[IDX_W-1:0]};
    endfunction

endpackage

`default_nettype wire

// ===== design/psr_front.sv =====
// Front end: accepts records, looks up per-stream state, classifies and
// updates it, and pushes one command per record. Depends on psr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module psr_front
    import psr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                action,
    input  logic                traffic_class,
    input  logic [STREAM_W-1:0] stream_index,
    input  logic [SEQ_W-1:0]    sequence_number,
    input  logic [HANDLE_W-1:0] record_handle,
    output logic                push,
    output cmd_t                push_cmd,
    input  logic                q_full
);

    typedef enum logic [1:0] {
        F_IDLE = 2'b01,
        F_LOOK = 2'b10
    } fstate_t;

    fstate_t               state_reg, state_next;
    logic [NSTREAMS-1:0]   svld_reg, svld_next;
    sstate_t               smem [NSTREAMS];
    sstate_t               rd_reg;
    logic                  rd_vld_reg;
    action_t               act_reg;
    logic                  cls_reg;
    logic [STREAM_W-1:0]   strm_reg;
    logic [SEQ_W-1:0]      seq_reg;
    logic [HANDLE_W-1:0]   handle_reg;

    logic                  accept;
    logic [SID_W-1:0]      sid_in;
    logic [SID_W-1:0]      sid_reg;
    sstate_t               cur;
    logic [SEQ_W-1:0]      offset;
    logic [WINDOW-1:0]     adv;
    logic [WINDOW-1:0]     run;
    logic [CNT_W-1:0]      drain;
    logic                  wr_en;
    logic                  wr;
    sstate_t               wr_data;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == F_IDLE);
    assign sid_in   = stream_id(traffic_class, stream_index);
    assign sid_reg  = stream_id(cls_reg, strm_reg);

    always_comb
    begin
        cur    = rd_vld_reg ? rd_reg : '0;
        offset = seq_reg - cur.expected;
        adv    = cur.held >> 1;
        run    = adv & ~(adv + WINDOW'(1));
        drain  = CNT_W'($countones(run));

        push_cmd.status = ST_REJECTED;
        push_cmd.cls    = cls_reg;
        push_cmd.stream = strm_reg;
        push_cmd.seq    = seq_reg;
        push_cmd.handle = handle_reg;
        push_cmd.drain  = '0;
        wr_en           = 1'b0;
        wr_data         = cur;

        if (act_reg == ACT_CLEAR)
        begin
            push_cmd.status = ST_CLEARED;
            push_cmd.seq    = '0;
            push_cmd.handle = '0;
            wr_en           = 1'b1;
            wr_data         = '0;
        end
        else if (offset == '0)
        begin
            push_cmd.status  = ST_RELEASED;
            push_cmd.drain   = drain;
            wr_en            = 1'b1;
            wr_data.expected = cur.expected + SEQ_W'(drain) + SEQ_W'(1);
            wr_data.held     = adv >> drain;
        end
        else if (offset[SEQ_W-1:SLOT_W] == '0)
        begin
            push_cmd.status = ST_HELD;
            wr_en           = 1'b1;
            wr_data.held    = cur.held | (WINDOW'(1) << offset[SLOT_W-1:0]);
        end
    end

    assign push = (state_reg == F_LOOK) && !q_full;
    assign wr   = push && wr_en;

    always_comb
    begin
        state_next = state_reg;
        svld_next  = svld_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    state_next = F_LOOK;
                end
            end
            F_LOOK:
            begin
                if (push)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
        if (wr)
        begin
            svld_next[sid_reg] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            svld_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            svld_reg  <= svld_next;
        end
    end

    // hold the record and the looked-up stream valid flag
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg    <= action_t'(action);
            cls_reg    <= traffic_class;
            strm_reg   <= stream_index;
            seq_reg    <= sequence_number;
            handle_reg <= record_handle;
            rd_vld_reg <= svld_reg[sid_in];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            smem[sid_reg] <= wr_data;
        end
        if (accept)
        begin
            rd_reg <= smem[sid_in];
        end
    end

endmodule

`default_nettype wire

// ===== design/psr_queue.sv =====
// Command queue between front and back ends.
// Depends on psr_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "per_stream_sequence_reorderer_macros.svh"

module psr_queue
    import psr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output cmd_t pop_cmd,
    output logic empty
);

    cmd_t                q_mem [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]     count_reg, count_next;

    assign full    = (count_reg == (QPTR_W+1)'(QDEPTH));
    assign empty   = (count_reg == '0);
    assign pop_cmd = q_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + (QPTR_W+1)'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - (QPTR_W+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= push_cmd;
        end
    end

    `PSR_ASSERT_NOW(a_q_no_overflow, push, !full || pop)
    `PSR_ASSERT_NOW(a_q_no_underflow, pop, !empty)

endmodule

`default_nettype wire

// ===== design/psr_back.sv =====
// Back end: executes commands, stores held handles, drains successors and
// drives the result register. Depends on psr_pkg and the macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "per_stream_sequence_reorderer_macros.svh"

module psr_back
    import psr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  cmd_t                head,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [1:0]          status,
    output logic                out_class,
    output logic [STREAM_W-1:0] out_stream,
    output logic [SEQ_W-1:0]    out_sequence,
    output logic [HANDLE_W-1:0] out_handle,
    output logic                last
);

    typedef enum logic [1:0] {
        B_IDLE = 2'b01,
        B_SEND = 2'b10
    } bstate_t;

    bstate_t               state_reg, state_next;
    cmd_t                  cmd_reg, cmd_next;
    logic                  sel_mem_reg, sel_mem_next;
    logic [HANDLE_W-1:0]   hmem [HMEM_DEPTH];
    logic [HANDLE_W-1:0]   hrd_reg;

    logic                  take;
    logic                  step;
    logic                  hold_wr;
    logic [SEQ_W-1:0]      seq_inc;
    logic [HADDR_W-1:0]    wr_addr;
    logic [HADDR_W-1:0]    rd_addr;

    assign out_valid = (state_reg == B_SEND);
    assign take      = out_valid && out_ready;
    assign pop       = !q_empty && ((state_reg == B_IDLE) || (take && cmd_reg.drain == '0));
    assign step      = take && (cmd_reg.drain != '0);
    assign hold_wr   = pop && (head.status == ST_HELD);
    assign seq_inc   = cmd_reg.seq + SEQ_W'(1);
    assign wr_addr   = {stream_id(head.cls, head.stream), head.seq[SLOT_W-1:0]};
    assign rd_addr   = {stream_id(cmd_reg.cls, cmd_reg.stream), seq_inc[SLOT_W-1:0]};

    always_comb
    begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        sel_mem_next = sel_mem_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (pop)
                begin
                    state_next = B_SEND;
                end
            end
            B_SEND:
            begin
                if (take && !step && !pop)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
        if (pop)
        begin
            cmd_next     = head;
            sel_mem_next = 1'b0;
        end
        else if (step)
        begin
            // advance to the next held successor
            cmd_next.seq   = seq_inc;
            cmd_next.drain = cmd_reg.drain - CNT_W'(1);
            sel_mem_next   = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= B_IDLE;
            sel_mem_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            sel_mem_reg <= sel_mem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

    always_ff @(posedge clk)
    begin
        if (hold_wr)
        begin
            hmem[wr_addr] <= head.handle;
        end
        if (step)
        begin
            hrd_reg <= hmem[rd_addr];
        end
    end

    assign status       = cmd_reg.status;
    assign out_class    = cmd_reg.cls;
    assign out_stream   = cmd_reg.stream;
    assign out_sequence = cmd_reg.seq;
    assign out_handle   = sel_mem_reg ? hrd_reg : cmd_reg.handle;
    assign last         = (cmd_reg.drain == '0);

    `PSR_ASSERT_NOW(a_drain_is_release, sel_mem_reg, cmd_reg.status == ST_RELEASED)
    `PSR_ASSERT_NOW(a_hold_no_drain, hold_wr, head.drain == '0)
    `PSR_ASSERT_NEXT(a_drain_seq_follows, step, out_sequence == ($past(out_sequence) + SEQ_W'(1)))

endmodule

`default_nettype wire

// ===== design/per_stream_sequence_reorderer.sv =====
// Top level of the per-stream sequence reorderer: front end, command queue
// and back end. Depends on psr_pkg, psr_front, psr_queue and psr_back.
//
//  Channel  Handshake               Payload
//  input    in_valid / in_ready     action, traffic_class, stream_index,
//                                   sequence_number, record_handle
//  output   out_valid / out_ready   status, out_class, out_stream, out_sequence,
//                                   out_handle, last
//
// The front end takes a new record only once the last is pushed: a stream state
// memory read, then the classify and update cycle that writes it back. The back
// end gives one result per cycle while out_ready is high and work waits, drained
// successors included, set by its single handle memory read port; a 4-entry
// queue separates the two sides. Reset clears the 128 per-stream valid flops at
// once; no clearing pass. A stalled output fills the queue, then the front end.
`timescale 1ns / 1ps
`default_nettype none

module per_stream_sequence_reorderer
    import psr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                action,
    input  logic                traffic_class,
    input  logic [STREAM_W-1:0] stream_index,
    input  logic [SEQ_W-1:0]    sequence_number,
    input  logic [HANDLE_W-1:0] record_handle,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [1:0]          status,
    output logic                out_class,
    output logic [STREAM_W-1:0] out_stream,
    output logic [SEQ_W-1:0]    out_sequence,
    output logic [HANDLE_W-1:0] out_handle,
    output logic                last
);

    logic push;
    cmd_t push_cmd;
    logic q_full;
    logic pop;
    cmd_t head;
    logic q_empty;

    psr_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .action          (action),
        .traffic_class   (traffic_class),
        .stream_index    (stream_index),
        .sequence_number (sequence_number),
        .record_handle   (record_handle),
        .push            (push),
        .push_cmd        (push_cmd),
        .q_full          (q_full)
    );

    psr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .pop_cmd  (head),
        .empty    (q_empty)
    );

    psr_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .head         (head),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .out_class    (out_class),
        .out_stream   (out_stream),
        .out_sequence (out_sequence),
        .out_handle   (out_handle),
        .last         (last)
    );

endmodule

`default_nettype wire
